// ----- rtl/averaging_voltmeter_display_driver_core_assert.svh -----
// Assertion macros for the averaging voltmeter display driver.
// Used by avdd_back; expects clk and rst_n in the including scope.
`ifndef AVERAGING_VOLTMETER_DISPLAY_DRIVER_CORE_ASSERT_SVH
`define AVERAGING_VOLTMETER_DISPLAY_DRIVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked while out of reset
`define AVDD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included
`define AVDD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AVDD_ASSERT(label, prop, msg)
`define AVDD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- rtl/avdd_pkg.sv -----
// Shared types, constants and helper functions of the voltmeter display driver.
// No dependencies; used by every RTL module.
package avdd_pkg;

  // Block length default
  localparam int SAMPLES_DEF = 100;

  // Field widths
  localparam int SAMPLE_W = 8;
  localparam int SUM_W    = 15;
  localparam int COUNT_W  = 7;
  localparam int SHOWN_W  = 11;
  localparam int SEG_W    = 8;
  localparam int EN_W     = 3;

  // Average scaling: shown = (sum * SCALE_MUL) >> SCALE_SHIFT, exact for sums up to 255*128
  localparam int SCALE_SHIFT = 27;
  localparam int SCALE_MUL_W = 30;
  localparam int SCALE_NUM   = 100;
  localparam int SCALE_FULL  = 17;

  // Decoupling queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Command kinds produced by the front end
  localparam logic [1:0] CMD_SAMPLE    = 2'd0;
  localparam logic [1:0] CMD_TICK_IDLE = 2'd1;
  localparam logic [1:0] CMD_TICK_ACT  = 2'd2;

  // Input operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Reciprocal constants for the digit split of an 11-bit value
  localparam int DIV_PROD_W   = 23;
  localparam logic [11:0] DIV10_MUL   = 12'd3277;  // >> 15
  localparam logic [11:0] DIV100_MUL  = 12'd2622;  // >> 18
  localparam logic [11:0] DIV1000_MUL = 12'd2098;  // >> 21

  typedef struct packed {
    logic                operation;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [SEG_W-1:0]   segments;
    logic [EN_W-1:0]    digit_enable;
    logic [SHOWN_W-1:0] shown_hundredths;
    logic               new_average;
  } out_item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SAMPLE_W-1:0] sample;
  } cmd_t;

  // 7-segment patterns, a..g in bits 0-6
  function automatic logic [SEG_W-1:0] seg_glyph(input logic [3:0] d);
    logic [SEG_W-1:0] g;
    case (d)
      4'd0:    g = 8'h3f;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5b;
      4'd3:    g = 8'h4f;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6d;
      4'd6:    g = 8'h7d;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7f;
      default: g = 8'h67;  // nine, and anything above is clamped to nine
    endcase
    return g;
  endfunction

  function automatic logic [7:0] div10(input logic [SHOWN_W-1:0] v);
    logic [DIV_PROD_W-1:0] p;
    p = DIV_PROD_W'(v) * DIV_PROD_W'(DIV10_MUL);
    return p[22:15];
  endfunction

  function automatic logic [4:0] div100(input logic [SHOWN_W-1:0] v);
    logic [DIV_PROD_W-1:0] p;
    p = DIV_PROD_W'(v) * DIV_PROD_W'(DIV100_MUL);
    return p[22:18];
  endfunction

  function automatic logic [1:0] div1000(input logic [SHOWN_W-1:0] v);
    logic [DIV_PROD_W-1:0] p;
    p = DIV_PROD_W'(v) * DIV_PROD_W'(DIV1000_MUL);
    return p[22:21];
  endfunction

endpackage

// ----- rtl/avdd_front.sv -----
// Front end: classifies each accepted item and runs the refresh-tick prescaler.
// Depends on avdd_pkg.
module avdd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  avdd_pkg::in_item_t in_data,
  output avdd_pkg::cmd_t    cmd
);
  import avdd_pkg::*;

  logic [1:0] prescale_r, prescale_nxt;
  logic       tick_acts;

  // Prescaler acts on the fourth tick after reset, then every third
  assign tick_acts = (prescale_r == 2'd3);

  always_comb begin
    prescale_nxt = prescale_r;
    if (accept && (in_data.operation == OP_TICK)) begin
      prescale_nxt = tick_acts ? 2'd1 : prescale_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= 2'd0;
    end else begin
      prescale_r <= prescale_nxt;
    end
  end

  // Command classification
  always_comb begin
    cmd.sample = in_data.sample;
    if (in_data.operation == OP_SAMPLE) begin
      cmd.kind = CMD_SAMPLE;
    end else if (tick_acts) begin
      cmd.kind = CMD_TICK_ACT;
    end else begin
      cmd.kind = CMD_TICK_IDLE;
    end
  end

endmodule

// ----- rtl/avdd_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on avdd_pkg.
module avdd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  avdd_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           pop,
  output avdd_pkg::cmd_t rd_cmd,
  output logic           empty
);
  import avdd_pkg::*;

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               wr_en, rd_en;

  assign full   = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty  = (count_r == '0);
  assign wr_en  = push && !full;
  assign rd_en  = pop && !empty;
  assign rd_cmd = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// ----- rtl/avdd_back.sv -----
// Back end: sample accumulation, average scaling, digit multiplexing, result register.
// Depends on avdd_pkg and the assertion macro header.
`include "averaging_voltmeter_display_driver_core_assert.svh"
module avdd_back #(
  parameter int SAMPLES = avdd_pkg::SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  avdd_pkg::cmd_t     q_cmd,
  input  logic               q_empty,
  output logic               q_pop,
  output avdd_pkg::out_item_t out_data,
  output logic               out_empty,
  input  logic               out_pop
);
  import avdd_pkg::*;

  localparam logic [1:0] PHASE_UNITS    = 2'd1;
  localparam logic [1:0] PHASE_TENS     = 2'd2;
  localparam logic [1:0] PHASE_HUNDREDS = 2'd3;

  localparam logic [EN_W-1:0] EN_UNITS    = 3'b001;
  localparam logic [EN_W-1:0] EN_TENS     = 3'b010;
  localparam logic [EN_W-1:0] EN_HUNDREDS = 3'b100;

  localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;

  localparam int PROD_W = SUM_W + SCALE_MUL_W;
  localparam longint unsigned ScaleDen = longint'(SCALE_FULL) * longint'(SAMPLES);
  localparam longint unsigned ScaleNumer = longint'(SCALE_NUM) << SCALE_SHIFT;
  localparam logic [SCALE_MUL_W-1:0] ScaleMul =
    SCALE_MUL_W'((ScaleNumer + ScaleDen - 1) / ScaleDen);
  localparam logic [COUNT_W-1:0] LastCount = COUNT_W'(SAMPLES - 1);

  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [SHOWN_W-1:0] shown_r, shown_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [SEG_W-1:0]   seg_r, seg_nxt;
  logic [EN_W-1:0]    en_r, en_nxt;
  logic               done;
  out_item_t          out_r;
  logic               out_valid_r, out_valid_nxt;
  logic               take;

  logic [SUM_W-1:0]  sum_added;
  logic [PROD_W-1:0] scaled;

  logic              tenths;
  logic [7:0]        q10;
  logic [4:0]        q100;
  logic [1:0]        q1000;
  logic [3:0]        d0, d1, d2;
  logic [3:0]        dig_units, dig_tens, dig_hundreds;

  // Work on the queue head when the result register is free or being drained
  assign take      = !q_empty && (!out_valid_r || out_pop);
  assign q_pop     = take;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  // Accumulate and scale the completed block average
  assign sum_added = sum_r + SUM_W'(q_cmd.sample);
  assign scaled    = PROD_W'(sum_added) * PROD_W'(ScaleMul);

  // Digit split of the shown value, all from parallel reciprocal multiplies
  assign tenths = (shown_r >= SHOWN_W'(1000));
  assign q10    = div10(shown_r);
  assign q100   = div100(shown_r);
  assign q1000  = div1000(shown_r);
  assign d0     = 4'(shown_r - SHOWN_W'(q10) * SHOWN_W'(10));
  assign d1     = 4'(q10 - 8'(q100) * 8'd10);
  assign d2     = 4'(q100 - 5'(q1000) * 5'd10);

  assign dig_units    = tenths ? d1 : d0;
  assign dig_tens     = tenths ? d2 : d1;
  assign dig_hundreds = tenths ? 4'(q1000) : 4'(q100);

  // State update for the command at the queue head
  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    shown_nxt = shown_r;
    phase_nxt = phase_r;
    seg_nxt   = seg_r;
    en_nxt    = en_r;
    done      = 1'b0;
    case (q_cmd.kind)
      CMD_SAMPLE: begin
        if (count_r >= LastCount) begin
          shown_nxt = scaled[SCALE_SHIFT +: SHOWN_W];
          sum_nxt   = '0;
          count_nxt = '0;
          done      = 1'b1;
        end else begin
          sum_nxt   = sum_added;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_TICK_ACT: begin
        case (phase_r)
          PHASE_UNITS: begin
            seg_nxt   = seg_glyph(dig_units);
            en_nxt    = EN_UNITS;
            phase_nxt = PHASE_TENS;
          end
          PHASE_TENS: begin
            seg_nxt   = seg_glyph(dig_tens) | (tenths ? SEG_POINT : '0);
            en_nxt    = EN_TENS;
            phase_nxt = PHASE_HUNDREDS;
          end
          PHASE_HUNDREDS: begin
            seg_nxt   = seg_glyph(dig_hundreds) | (tenths ? '0 : SEG_POINT);
            en_nxt    = EN_HUNDREDS;
            phase_nxt = PHASE_UNITS;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Result register valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      count_r     <= '0;
      shown_r     <= '0;
      phase_r     <= PHASE_UNITS;
      seg_r       <= '0;
      en_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
        shown_r <= shown_nxt;
        phase_r <= phase_nxt;
        seg_r   <= seg_nxt;
        en_r    <= en_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_r.segments         <= seg_nxt;
      out_r.digit_enable     <= en_nxt;
      out_r.shown_hundredths <= shown_nxt;
      out_r.new_average      <= done;
    end
  end

  `AVDD_ASSERT(a_enable_onehot, $onehot0(en_r), "digit enable not one-hot")
  `AVDD_ASSERT(a_phase_nonzero, phase_r != 2'd0, "digit phase left its cycle")
  `AVDD_ASSERT(a_count_in_block, count_r <= LastCount, "sample count beyond block")
  `AVDD_ASSERT(a_avg_restarts, (out_valid_r && out_r.new_average) |-> (count_r == '0 && sum_r == '0), "block not restarted after average")
  `AVDD_ASSERT(a_enable_matches_phase, (en_r == EN_UNITS) |-> (phase_r == PHASE_TENS), "phase out of step with lit digit")

endmodule

// ----- rtl/averaging_voltmeter_display_driver_core.sv -----
// Top level of the averaging voltmeter display driver.
// Depends on avdd_pkg, avdd_front, avdd_queue and avdd_back.
//
// Takes converter samples and refresh ticks through a push/full queue port and
// returns one result per item through an empty/pop port. One item is accepted
// per clock and one result delivered per clock when neither side stalls. A result
// passes through the four-entry command queue and then the back end's result
// register before it can be popped. The back end does the sample-sum update, the
// scaling multiply and the digit split combinationally for the item at the queue
// head, which sets this rate. The refresh prescaler runs at the input; the queue
// absorbs short result stalls.
module averaging_voltmeter_display_driver_core #(
  parameter int SAMPLES = avdd_pkg::SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  avdd_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output avdd_pkg::out_item_t out_data
);
  import avdd_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full, q_empty, q_pop;
  logic accept;

  assign accept = push && !q_full;
  assign full   = q_full;

  // Classification and prescaling
  avdd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .cmd     (front_cmd)
  );

  // Decoupling queue
  avdd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (front_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .rd_cmd (head_cmd),
    .empty  (q_empty)
  );

  // Execution and result register
  avdd_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (head_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_data  (out_data),
    .out_empty (empty),
    .out_pop   (pop)
  );

endmodule

// ----- test/averaging_voltmeter_display_driver_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for averaging_voltmeter_display_driver_core.
// Depends on avdd_pkg and the core RTL; keeps its own model of the averaged
// reading and the multiplexed display and checks every returned reading.
module averaging_voltmeter_display_driver_core_tb;
  import avdd_pkg::*;

  localparam int NSAMP       = SAMPLES_DEF;
  localparam int MAX_GAP     = 8;
  localparam int RST_CYCLES  = 4;
  localparam int DRAIN_CYCLES = 20;
  localparam int NOISE_ITEMS = 40;
  localparam int TENTHS_FROM = 1000;
  // constant reading whose block average lands exactly on 10.00 V
  localparam int TENTHS_LEVEL = TENTHS_FROM * SCALE_FULL / SCALE_NUM;

  localparam logic [1:0] PRESC_ACT   = 2'd3;
  localparam logic [1:0] PH_UNITS    = 2'd1;
  localparam logic [1:0] PH_TENS     = 2'd2;
  localparam logic [1:0] PH_HUNDREDS = 2'd3;
  localparam logic [EN_W-1:0] EN_OFF      = 3'b000;
  localparam logic [EN_W-1:0] EN_UNITS    = 3'b001;
  localparam logic [EN_W-1:0] EN_TENS     = 3'b010;
  localparam logic [EN_W-1:0] EN_HUNDREDS = 3'b100;
  localparam logic [SEG_W-1:0] DP_BIT     = 8'h80;

  typedef enum int {
    BLK_RANDOM, BLK_FULL, BLK_AT_TENTHS, BLK_STYLES
  } blk_style_t;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_data;
  logic      empty;
  logic      pop;
  out_item_t out_data;

  averaging_voltmeter_display_driver_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  // Model state of the meter
  logic [SUM_W-1:0]   blk_sum;
  logic [COUNT_W-1:0] blk_count;
  logic [SHOWN_W-1:0] shown_val;
  logic [1:0]         presc;
  logic [1:0]         phase;
  logic [SEG_W-1:0]   seg_q;
  logic [EN_W-1:0]    en_q;

  out_item_t pending_readings[$];
  dir_row_t  dir_rows[$];
  int        mismatch_count = 0;
  bit        send_steady = 1'b0;
  bit        sink_steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Segment pattern of one decimal digit; out-of-range digits show as nine
  function automatic logic [SEG_W-1:0] glyph_of(input int unsigned d);
    case ((d > 9) ? 9 : d)
      0:       return 8'h3f;
      1:       return 8'h06;
      2:       return 8'h5b;
      3:       return 8'h4f;
      4:       return 8'h66;
      5:       return 8'h6d;
      6:       return 8'h7d;
      7:       return 8'h07;
      8:       return 8'h7f;
      default: return 8'h67;
    endcase
  endfunction

  // Advance the meter model by one transfer and return the reading it shows
  task automatic step_meter_model(input in_item_t it, output out_item_t r);
    int unsigned n;
    bit          tenths;
    logic        done;
    done = 1'b0;
    if (it.operation == OP_SAMPLE) begin
      blk_sum = blk_sum + SUM_W'(it.sample);
      if (blk_count >= COUNT_W'(NSAMP - 1)) begin
        shown_val = SHOWN_W'((int'(blk_sum) * SCALE_NUM) / (SCALE_FULL * NSAMP));
        blk_sum   = '0;
        blk_count = '0;
        done      = 1'b1;
      end else begin
        blk_count = blk_count + 1'b1;
      end
    end else if (presc != PRESC_ACT) begin
      presc = presc + 1'b1;
    end else begin
      presc  = 2'd1;
      tenths = (shown_val >= TENTHS_FROM);
      n      = tenths ? shown_val / 10 : shown_val;
      case (phase)
        PH_UNITS: begin
          seg_q = glyph_of(n % 10);
          en_q  = EN_UNITS;
          phase = PH_TENS;
        end
        PH_TENS: begin
          seg_q = glyph_of((n % 100) / 10) | (tenths ? DP_BIT : '0);
          en_q  = EN_TENS;
          phase = PH_HUNDREDS;
        end
        PH_HUNDREDS: begin
          seg_q = glyph_of(n / 100) | (tenths ? '0 : DP_BIT);
          en_q  = EN_HUNDREDS;
          phase = PH_UNITS;
        end
        default: ;  // a zero phase leaves the display untouched
      endcase
    end
    r.segments         = seg_q;
    r.digit_enable     = en_q;
    r.shown_hundredths = shown_val;
    r.new_average      = done;
  endtask

  task automatic add_row(input logic op, input logic [SAMPLE_W-1:0] smp, input logic typed,
                         input logic [SEG_W-1:0] seg, input logic [EN_W-1:0] en,
                         input logic [SHOWN_W-1:0] shown);
    dir_row_t r;
    r.item.operation         = op;
    r.item.sample            = smp;
    r.typed                  = typed;
    r.want.segments          = seg;
    r.want.digit_enable      = en;
    r.want.shown_hundredths  = shown;
    r.want.new_average       = 1'b0;
    dir_rows.push_back(r);
  endtask

  // One input transfer after a random gap; the reading is predicted on acceptance
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    int        gap;
    out_item_t pred;
    if ($urandom_range(0, 15) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    step_meter_model(it, pred);
    pending_readings.push_back(typed ? want : pred);
  endtask

  // Stimulus
  initial begin : stimulus
    in_item_t   it;
    blk_style_t style;
    int         n_blk;
    rst_n   = 1'b0;
    push    = 1'b0;
    in_data = '0;
    blk_sum   = '0;
    blk_count = '0;
    shown_val = '0;
    presc     = '0;
    phase     = PH_UNITS;
    seg_q     = '0;
    en_q      = EN_OFF;

    // Directed table: prescaler start-up, a full digit cycle, field extremes
    add_row(OP_TICK,   8'h00, 1'b1, 8'h00, EN_OFF, '0);
    add_row(OP_SAMPLE, 8'hff, 1'b1, 8'h00, EN_OFF, '0);
    add_row(OP_TICK,   8'h00, 1'b1, 8'h00, EN_OFF, '0);
    add_row(OP_SAMPLE, 8'h00, 1'b1, 8'h00, EN_OFF, '0);
    add_row(OP_TICK,   8'h00, 1'b1, 8'h00, EN_OFF, '0);
    add_row(OP_TICK,   8'h00, 1'b1, 8'h3f, EN_UNITS, '0);     // fourth tick lights units
    add_row(OP_SAMPLE, 8'haa, 1'b0, 8'h00, EN_OFF, '0);
    add_row(OP_SAMPLE, 8'h55, 1'b0, 8'h00, EN_OFF, '0);
    add_row(OP_TICK,   8'hff, 1'b0, 8'h00, EN_OFF, '0);       // sample ignored on a tick
    add_row(OP_TICK,   8'h00, 1'b0, 8'h00, EN_OFF, '0);
    add_row(OP_TICK,   8'h00, 1'b1, 8'h3f, EN_TENS, '0);
    add_row(OP_TICK,   8'h5a, 1'b0, 8'h00, EN_OFF, '0);
    add_row(OP_TICK,   8'h00, 1'b0, 8'h00, EN_OFF, '0);
    add_row(OP_TICK,   8'h00, 1'b1, 8'hbf, EN_HUNDREDS, '0);  // point on hundreds below 10 V
    add_row(OP_TICK,   8'h00, 1'b0, 8'h00, EN_OFF, '0);
    add_row(OP_TICK,   8'h00, 1'b0, 8'h00, EN_OFF, '0);
    add_row(OP_TICK,   8'h00, 1'b0, 8'h00, EN_OFF, '0);       // wraps back to units
    add_row(OP_SAMPLE, 8'h01, 1'b0, 8'h00, EN_OFF, '0);
    add_row(OP_SAMPLE, 8'h80, 1'b0, 8'h00, EN_OFF, '0);
    add_row(OP_SAMPLE, 8'hfe, 1'b0, 8'h00, EN_OFF, '0);
    add_row(OP_SAMPLE, 8'h7f, 1'b0, 8'h00, EN_OFF, '0);

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_rows.size(); i++)
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // Hold the input until every reading is back
    push <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);

    // Averaging blocks with random ticks; the first one completes the open block
    for (int b = 0; b < BLK_STYLES; b++) begin
      style = blk_style_t'(b);
      n_blk = NSAMP - int'(blk_count);
      for (int k = 0; k < n_blk; k++) begin
        it.operation = OP_SAMPLE;
        case (style)
          BLK_FULL:      it.sample = 8'hff;
          BLK_AT_TENTHS: it.sample = SAMPLE_W'(TENTHS_LEVEL);
          default:       it.sample = SAMPLE_W'($urandom_range(0, 255));
        endcase
        send_item(it, 1'b0, '0);
        if ($urandom_range(0, 7) == 0) begin
          it.operation = OP_TICK;
          it.sample    = SAMPLE_W'($urandom_range(0, 255));
          send_item(it, 1'b0, '0);
        end
      end
      // enough ticks to scan all three digits of the new value
      repeat (9) begin
        it.operation = OP_TICK;
        it.sample    = SAMPLE_W'($urandom_range(0, 255));
        send_item(it, 1'b0, '0);
      end
    end

    // Unstructured mix
    repeat (NOISE_ITEMS) begin
      it.operation = $urandom_range(0, 1) ? OP_TICK : OP_SAMPLE;
      it.sample    = SAMPLE_W'($urandom_range(0, 255));
      send_item(it, 1'b0, '0);
    end

    push <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Result side: random pop gaps, each transfer checked against the oldest prediction
  initial begin : reading_sink
    int        gap;
    out_item_t want;
    pop = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_steady = !sink_steady;
      gap = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (pending_readings.size() == 0) begin
        $error("unexpected reading: %h", out_data);
        mismatch_count++;
      end else begin
        want = pending_readings.pop_front();
        if (out_data.segments !== want.segments) begin
          $error("segments: expected %h, got %h", want.segments, out_data.segments);
          mismatch_count++;
        end
        if (out_data.digit_enable !== want.digit_enable) begin
          $error("digit_enable: expected %b, got %b", want.digit_enable,
                 out_data.digit_enable);
          mismatch_count++;
        end
        if (out_data.shown_hundredths !== want.shown_hundredths) begin
          $error("shown_hundredths: expected %0d, got %0d", want.shown_hundredths,
                 out_data.shown_hundredths);
          mismatch_count++;
        end
        if (out_data.new_average !== want.new_average) begin
          $error("new_average: expected %b, got %b", want.new_average,
                 out_data.new_average);
          mismatch_count++;
        end
      end
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- averaging_voltmeter_display_driver_core.f -----
+incdir+rtl
rtl/avdd_pkg.sv
rtl/avdd_front.sv
rtl/avdd_queue.sv
rtl/avdd_back.sv
rtl/averaging_voltmeter_display_driver_core.sv
test/averaging_voltmeter_display_driver_core_tb.sv
